@@ src/mts_pkg.sv @@
// Package for the min-tracking stack: sizes, operation and status codes,
// and the shift control word shared by the cell chain. No dependencies.
package mts_pkg;

  localparam int Depth     = 64;
  localparam int DataWidth = 32;
  localparam int CntW      = $clog2(Depth + 1);

  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusPopEmpty  = 2'd1;
  localparam logic [1:0] StatusPushFull  = 2'd2;

  typedef logic signed [DataWidth-1:0] data_t;

  // push shifts every cell one place deeper, pop one place toward the top
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

@@ src/mts_cell.sv @@
// One stack entry of the cell chain.
// Depends on mts_pkg (data_t, shift_ctrl_t).
module mts_cell (
  input  logic                clk_i,
  input  mts_pkg::shift_ctrl_t ctrl_i,
  input  mts_pkg::data_t      from_above_i,
  input  mts_pkg::data_t      from_below_i,
  output mts_pkg::data_t      data_o
);

  mts_pkg::data_t data_q;
  mts_pkg::data_t data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = from_above_i;
    end else if (ctrl_i.pop) begin
      data_d = from_below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ src/mts_chain.sv @@
// Row of mts_cell entries forming one shift stack; cell 0 is the top.
// Depends on mts_pkg and mts_cell.
module mts_chain (
  input  logic                 clk_i,
  input  mts_pkg::shift_ctrl_t ctrl_i,
  input  mts_pkg::data_t       push_data_i,
  output mts_pkg::data_t       top_o,
  output mts_pkg::data_t       second_o
);

  mts_pkg::data_t cell_data [mts_pkg::Depth];

  for (genvar i = 0; i < mts_pkg::Depth; i++) begin : g_cell
    mts_pkg::data_t above;
    mts_pkg::data_t below;

    if (i == 0) begin : g_first
      assign above = push_data_i;
    end else begin : g_rest
      assign above = cell_data[i-1];
    end

    // bottom cell refills with a don't-care word; it lies past the count
    if (i == mts_pkg::Depth - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_data[i+1];
    end

    mts_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .from_above_i(above),
      .from_below_i(below),
      .data_o      (cell_data[i])
    );
  end

  assign top_o    = cell_data[0];
  assign second_o = cell_data[1];

endmodule

@@ src/min_tracking_stack_unit.sv @@
// Top level of the min-tracking stack: two cell chains (entries, minima),
// their counts and the registered result word. Depends on mts_pkg, mts_chain.
//
//  channel | direction | signals
//  --------+-----------+-------------------------------------------------
//  in      | input     | in_valid_i, in_ready_o, cmd_i, value_i
//  out     | output    | out_valid_o, out_ready_i, top_value_o, min_value_o,
//          |           | is_empty_o, count_o, status_o
//
// One word per cycle unless the output stalls: a successful push or pop shifts
// the entries (and the minima if needed) as the result word is registered.
// A new word is taken while the output register is empty or being drained.
// Reset clears both counts and the output valid; cell contents are left as is.
// A stalled output holds its word and blocks the input until it is taken.
module min_tracking_stack_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic signed [mts_pkg::DataWidth-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [mts_pkg::DataWidth-1:0] top_value_o,
  output logic signed [mts_pkg::DataWidth-1:0] min_value_o,
  output logic                        is_empty_o,
  output logic [mts_pkg::CntW-1:0]    count_o,
  output logic [1:0]                  status_o
);

  logic [mts_pkg::CntW-1:0] main_cnt_q, main_cnt_d;
  logic [mts_pkg::CntW-1:0] min_cnt_q, min_cnt_d;
  logic                     out_valid_q;
  mts_pkg::data_t           top_q, min_q;
  mts_pkg::data_t           top_d, min_d;
  logic                     empty_q;
  logic [mts_pkg::CntW-1:0] count_q;
  logic [1:0]               status_q, status_d;

  mts_pkg::shift_ctrl_t main_ctrl, min_ctrl;
  mts_pkg::data_t       main_top, main_second, min_top, min_second;

  logic accept, push_ok, pop_ok, min_push, min_pop;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign push_ok  = accept && (cmd_i == mts_pkg::CmdPush) && (main_cnt_q != mts_pkg::DepthCnt);
  assign pop_ok   = accept && (cmd_i == mts_pkg::CmdPop) && (main_cnt_q != '0);
  assign min_push = push_ok && ((min_cnt_q == '0) || (value_i <= min_top));
  assign min_pop  = pop_ok && (min_cnt_q != '0) && (min_top == main_top);

  assign main_ctrl = '{push: push_ok, pop: pop_ok};
  assign min_ctrl  = '{push: min_push, pop: min_pop};

  mts_chain u_main (
    .clk_i      (clk_i),
    .ctrl_i     (main_ctrl),
    .push_data_i(value_i),
    .top_o      (main_top),
    .second_o   (main_second)
  );

  mts_chain u_min (
    .clk_i      (clk_i),
    .ctrl_i     (min_ctrl),
    .push_data_i(value_i),
    .top_o      (min_top),
    .second_o   (min_second)
  );

  always_comb begin
    main_cnt_d = main_cnt_q;
    min_cnt_d  = min_cnt_q;
    if (push_ok) main_cnt_d = main_cnt_q + 1'b1;
    if (pop_ok)  main_cnt_d = main_cnt_q - 1'b1;
    if (min_push) min_cnt_d = min_cnt_q + 1'b1;
    if (min_pop)  min_cnt_d = min_cnt_q - 1'b1;

    status_d = mts_pkg::StatusOk;
    if (cmd_i == mts_pkg::CmdPush && main_cnt_q == mts_pkg::DepthCnt) begin
      status_d = mts_pkg::StatusPushFull;
    end else if (cmd_i == mts_pkg::CmdPop && main_cnt_q == '0) begin
      status_d = mts_pkg::StatusPopEmpty;
    end

    // values the chains will hold after this word (reported as zero once empty)
    if (push_ok) begin
      top_d = value_i;
    end else if (pop_ok) begin
      top_d = main_second;
    end else begin
      top_d = main_top;
    end

    if (min_push) begin
      min_d = value_i;
    end else if (min_pop) begin
      min_d = min_second;
    end else begin
      min_d = min_top;
    end

    if (main_cnt_d == '0) begin
      top_d = '0;
      min_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_cnt_q  <= '0;
      min_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      main_cnt_q <= main_cnt_d;
      min_cnt_q  <= min_cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q    <= top_d;
      min_q    <= min_d;
      empty_q  <= (main_cnt_d == '0);
      count_q  <= main_cnt_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = top_q;
  assign min_value_o = min_q;
  assign is_empty_o  = empty_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

endmodule
